// ----- design/bada_pkg.sv -----
// Shared types and constants for the box area average downscaler.
`timescale 1ns / 1ps
package bada_pkg;

  localparam int SUM_W     = 24;
  localparam int PIX_W     = 32;
  localparam int COL_W     = 8;
  localparam int ROW_W     = 8;
  localparam int OW_W      = 9;
  localparam int OH_W      = 8;
  localparam int CFG_W     = 9;
  localparam int MAX_OUT_W = 256;
  localparam int MAX_OUT_H = 192;
  localparam int ADDR_W    = 8;

  localparam logic [7:0] ALPHA = 8'hFF;

  localparam logic CFG_OUT_WIDTH  = 1'b0;
  localparam logic CFG_OUT_HEIGHT = 1'b1;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t r;
    sum_t g;
    sum_t b;
  } sums_t;

  typedef enum logic [2:0] {
    S_PREP,
    S_IDLE,
    S_UPD,
    S_DIVGO,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ----- design/bada_sum_mem.sv -----
// Per-column partial sum memory, one write port, one registered read port.
`timescale 1ns / 1ps
module bada_sum_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bada_pkg::ADDR_W-1:0] waddr,
  input  bada_pkg::sums_t             wdata,
  input  logic [bada_pkg::ADDR_W-1:0] raddr,
  output bada_pkg::sums_t             rdata
);

  bada_pkg::sums_t mem [bada_pkg::MAX_OUT_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bada_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bada_div #(
  parameter int NW = 24,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- design/box_area_average_downscaler_unit.sv -----
// Top level of the box area average downscaler.
`timescale 1ns / 1ps
// Area-average downscaler: takes a SRC_WIDTH x SRC_HEIGHT raster of ARGB8888
// pixels and emits out_width x out_height averaged pixels (alpha forced to
// 0xFF), one when the bottom-right source pixel of a block arrives. Block
// edges are floor(i*SRC/OUT), tracked incrementally from a quotient and
// remainder of SRC/OUT that are worked out by a short iterative divide after
// reset and after each register write (input stalled meanwhile). Column sums
// live in a 256-entry memory read then written back; a fill count marks
// which entries were written since the last restart, so a restart needs no
// clearing pass. An item that closes no block takes a memory read, then an
// update and write-back. An item that closes a block adds the three-channel
// divide by the block's pixel count, a quotient bit at a time, plus setup
// and hand-off states. The result sits in an output register, so the next
// item is taken while it waits. frame_start restarts all counters and sums;
// a register write also restarts and saturates out-of-range values.
module box_area_average_downscaler_unit #(
  parameter int SRC_WIDTH  = 256,
  parameter int SRC_HEIGHT = 192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bada_pkg::PIX_W-1:0]   in_src_pixel,
  input  logic                         in_frame_start,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bada_pkg::PIX_W-1:0]   out_pixel,
  output logic [bada_pkg::COL_W-1:0]   out_col,
  output logic [bada_pkg::ROW_W-1:0]   out_row,
  output logic                         out_frame_last,
  // configuration writes
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [bada_pkg::CFG_W-1:0]   cfg_data
);

  // column/row counters and block edge widths
  localparam int CW   = $clog2(SRC_WIDTH);
  localparam int XW   = $clog2(SRC_WIDTH + 1);
  localparam int RW   = $clog2(SRC_HEIGHT);
  localparam int YW   = $clog2(SRC_HEIGHT + 1);
  localparam int NW   = XW + YW;
  localparam int LIMW = (SRC_WIDTH < bada_pkg::MAX_OUT_W) ? SRC_WIDTH : bada_pkg::MAX_OUT_W;
  localparam int LIMH = (SRC_HEIGHT < bada_pkg::MAX_OUT_H) ? SRC_HEIGHT : bada_pkg::MAX_OUT_H;
  localparam int OW   = bada_pkg::OW_W;
  localparam int OH   = bada_pkg::OH_W;

  bada_pkg::state_t state_r, state_nxt;

  // registers
  logic [OW-1:0] ow_r;
  logic [OH-1:0] oh_r;
  logic          prep_go_r;

  // block edge steps: SRC/OUT as quotient and remainder
  logic [XW-1:0] qs_r;
  logic [OW-1:0] rs_r;
  logic [YW-1:0] qh_r;
  logic [OH-1:0] rh_r;

  // raster position and current block
  logic [CW-1:0]               src_col_r, src_col_nxt;
  logic [RW-1:0]               src_row_r, src_row_nxt;
  logic [bada_pkg::COL_W-1:0]  dx_r, dx_nxt;
  logic [bada_pkg::ROW_W-1:0]  dy_r, dy_nxt;
  logic [XW-1:0]               x1_r, x1_nxt, bw_r, bw_nxt;
  logic [OW-1:0]               xr_r, xr_nxt;
  logic [YW-1:0]               y1_r, y1_nxt, bh_r, bh_nxt;
  logic [OH-1:0]               yr_r, yr_nxt;
  logic [OW-1:0]               fill_r, fill_nxt;

  // item and result payload
  logic [bada_pkg::PIX_W-1:0]  px_r;
  bada_pkg::sums_t             sum_lat_r;
  logic [NW-1:0]               n_r;
  logic [bada_pkg::COL_W-1:0]  res_col_r;
  logic [bada_pkg::ROW_W-1:0]  res_row_r;
  logic                        res_last_r;
  logic [23:0]                 res_rgb_r;

  logic                        out_valid_r;
  logic [bada_pkg::PIX_W-1:0]  out_pixel_r;
  logic [bada_pkg::COL_W-1:0]  out_col_r;
  logic [bada_pkg::ROW_W-1:0]  out_row_r;
  logic                        out_last_r;

  // memory
  logic                          mem_we;
  logic [bada_pkg::ADDR_W-1:0]   mem_raddr;
  bada_pkg::sums_t               mem_wdata;
  bada_pkg::sums_t               mem_rdata;
  bada_pkg::sums_t               cur_sums;
  bada_pkg::sums_t               new_sums;

  // dividers
  logic          xdiv_busy, xdiv_done, ydiv_busy, ydiv_done;
  logic [XW-1:0] xdiv_quo;
  logic [OW-1:0] xdiv_rem;
  logic [YW-1:0] ydiv_quo;
  logic [OH-1:0] ydiv_rem;
  logic          cdiv_start;
  logic          rdiv_busy, gdiv_busy, bdiv_busy;
  logic          rdiv_done, gdiv_done, bdiv_done;
  logic [bada_pkg::SUM_W-1:0] rdiv_quo, gdiv_quo, bdiv_quo;

  // combinational helpers
  logic          accept;
  logic          prep_ready;
  logic [OW-1:0] cfg_w_sat;
  logic [OH-1:0] cfg_h_sat;
  logic [XW-1:0] col_inc;
  logic [YW-1:0] row_inc;
  logic [OW-1:0] dx_inc;
  logic [OW-1:0] dy_inc;
  logic          col_hit, row_hit, emit;
  logic [OW:0]   xr_sum;
  logic          xcarry;
  logic [OH:0]   yr_sum;
  logic          ycarry;
  logic          out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != bada_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // saturate register writes into the legal range
  always_comb begin
    if (cfg_data == '0) begin
      cfg_w_sat = OW'(1);
    end else if (cfg_data > bada_pkg::CFG_W'(LIMW)) begin
      cfg_w_sat = OW'(LIMW);
    end else begin
      cfg_w_sat = cfg_data;
    end
    if (cfg_data == '0) begin
      cfg_h_sat = OH'(1);
    end else if (cfg_data > bada_pkg::CFG_W'(LIMH)) begin
      cfg_h_sat = OH'(LIMH);
    end else begin
      cfg_h_sat = cfg_data[OH-1:0];
    end
  end

  // step dividers: SRC_WIDTH/out_width and SRC_HEIGHT/out_height
  bada_div #(.NW(XW), .DW(OW)) u_xdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (prep_go_r),
    .num   (XW'(SRC_WIDTH)),
    .den   (ow_r),
    .busy  (xdiv_busy),
    .done  (xdiv_done),
    .quo   (xdiv_quo),
    .rem   (xdiv_rem)
  );

  bada_div #(.NW(YW), .DW(OH)) u_ydiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (prep_go_r),
    .num   (YW'(SRC_HEIGHT)),
    .den   (oh_r),
    .busy  (ydiv_busy),
    .done  (ydiv_done),
    .quo   (ydiv_quo),
    .rem   (ydiv_rem)
  );

  assign prep_ready = !prep_go_r && !xdiv_busy && !ydiv_busy;

  // channel dividers: block sum / pixel count
  assign cdiv_start = (state_r == bada_pkg::S_DIVGO);

  bada_div #(.NW(bada_pkg::SUM_W), .DW(NW)) u_rdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cdiv_start),
    .num   (sum_lat_r.r),
    .den   (n_r),
    .busy  (rdiv_busy),
    .done  (rdiv_done),
    .quo   (rdiv_quo),
    .rem   ()
  );

  bada_div #(.NW(bada_pkg::SUM_W), .DW(NW)) u_gdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cdiv_start),
    .num   (sum_lat_r.g),
    .den   (n_r),
    .busy  (gdiv_busy),
    .done  (gdiv_done),
    .quo   (gdiv_quo),
    .rem   ()
  );

  bada_div #(.NW(bada_pkg::SUM_W), .DW(NW)) u_bdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cdiv_start),
    .num   (sum_lat_r.b),
    .den   (n_r),
    .busy  (bdiv_busy),
    .done  (bdiv_done),
    .quo   (bdiv_quo),
    .rem   ()
  );

  // column sum memory
  bada_sum_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (dx_r),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // frame_start reads entry 0 of a freshly restarted frame
  assign mem_raddr = in_frame_start ? '0 : dx_r;

  // entries at or above the fill count were not written since restart
  always_comb begin
    cur_sums   = (fill_r > {1'b0, dx_r}) ? mem_rdata : '0;
    new_sums.r = cur_sums.r + bada_pkg::SUM_W'(px_r[23:16]);
    new_sums.g = cur_sums.g + bada_pkg::SUM_W'(px_r[15:8]);
    new_sums.b = cur_sums.b + bada_pkg::SUM_W'(px_r[7:0]);
  end

  // block edge tests and incremental edge steps
  always_comb begin
    col_inc = XW'(src_col_r) + XW'(1);
    row_inc = YW'(src_row_r) + YW'(1);
    dx_inc  = {1'b0, dx_r} + OW'(1);
    dy_inc  = {1'b0, dy_r} + OW'(1);
    col_hit = col_inc >= x1_r;
    row_hit = row_inc >= y1_r;
    emit    = col_hit && row_hit;
    xr_sum  = {1'b0, xr_r} + {1'b0, rs_r};
    xcarry  = xr_sum >= {1'b0, ow_r};
    yr_sum  = {1'b0, yr_r} + {1'b0, rh_r};
    ycarry  = yr_sum >= {1'b0, oh_r};
  end

  assign mem_we    = (state_r == bada_pkg::S_UPD);
  assign mem_wdata = emit ? '0 : new_sums;

  // next state and counter update
  always_comb begin
    state_nxt   = state_r;
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    x1_nxt      = x1_r;
    xr_nxt      = xr_r;
    bw_nxt      = bw_r;
    y1_nxt      = y1_r;
    yr_nxt      = yr_r;
    bh_nxt      = bh_r;
    fill_nxt    = fill_r;

    unique case (state_r)
      bada_pkg::S_PREP: begin
        if (prep_ready) begin
          state_nxt = bada_pkg::S_IDLE;
          x1_nxt = xdiv_quo;
          xr_nxt = xdiv_rem;
          bw_nxt = xdiv_quo;
          y1_nxt = ydiv_quo;
          yr_nxt = ydiv_rem;
          bh_nxt = ydiv_quo;
        end
      end
      bada_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = bada_pkg::S_UPD;
          if (in_frame_start) begin
            src_col_nxt = '0;
            src_row_nxt = '0;
            dx_nxt      = '0;
            dy_nxt      = '0;
            fill_nxt    = '0;
            x1_nxt      = qs_r;
            xr_nxt      = rs_r;
            bw_nxt      = qs_r;
            y1_nxt      = qh_r;
            yr_nxt      = rh_r;
            bh_nxt      = qh_r;
          end
        end
      end
      bada_pkg::S_UPD: begin
        state_nxt = emit ? bada_pkg::S_DIVGO : bada_pkg::S_IDLE;
        if (dx_inc > fill_r) begin
          fill_nxt = dx_inc;
        end
        if (col_hit) begin
          dx_nxt = dx_inc[bada_pkg::COL_W-1:0];
          bw_nxt = qs_r + XW'(xcarry);
          x1_nxt = x1_r + qs_r + XW'(xcarry);
          xr_nxt = xcarry ? OW'(xr_sum - {1'b0, ow_r}) : OW'(xr_sum);
        end
        src_col_nxt = CW'(col_inc);
        if (col_inc == XW'(SRC_WIDTH) || (col_hit && dx_inc >= ow_r)) begin
          dx_nxt = '0;
          x1_nxt = qs_r;
          xr_nxt = rs_r;
          bw_nxt = qs_r;
        end
        if (col_inc == XW'(SRC_WIDTH)) begin
          src_col_nxt = '0;
          src_row_nxt = RW'(row_inc);
          if (row_hit) begin
            dy_nxt = dy_inc[bada_pkg::ROW_W-1:0];
            bh_nxt = qh_r + YW'(ycarry);
            y1_nxt = y1_r + qh_r + YW'(ycarry);
            yr_nxt = ycarry ? OH'(yr_sum - {1'b0, oh_r}) : OH'(yr_sum);
          end
          if (row_inc == YW'(SRC_HEIGHT) || (row_hit && dy_inc >= {1'b0, oh_r})) begin
            dy_nxt = '0;
            y1_nxt = qh_r;
            yr_nxt = rh_r;
            bh_nxt = qh_r;
          end
          if (row_inc == YW'(SRC_HEIGHT)) begin
            src_row_nxt = '0;
          end
        end
      end
      bada_pkg::S_DIVGO: begin
        state_nxt = bada_pkg::S_DIV;
      end
      bada_pkg::S_DIV: begin
        if (rdiv_done) begin
          state_nxt = bada_pkg::S_OUT;
        end
      end
      bada_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = bada_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bada_pkg::S_PREP;
      end
    endcase

    // a register write restarts the frame
    if (cfg_wr_en) begin
      state_nxt   = bada_pkg::S_PREP;
      src_col_nxt = '0;
      src_row_nxt = '0;
      dx_nxt      = '0;
      dy_nxt      = '0;
      fill_nxt    = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bada_pkg::S_PREP;
      prep_go_r   <= 1'b1;
      ow_r        <= OW'(LIMW);
      oh_r        <= OH'(LIMH);
      src_col_r   <= '0;
      src_row_r   <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      fill_r      <= '0;
      x1_r        <= '0;
      xr_r        <= '0;
      bw_r        <= '0;
      y1_r        <= '0;
      yr_r        <= '0;
      bh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      prep_go_r <= cfg_wr_en;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bada_pkg::CFG_OUT_WIDTH:  ow_r <= cfg_w_sat;
          bada_pkg::CFG_OUT_HEIGHT: oh_r <= cfg_h_sat;
          default: ;
        endcase
      end
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      fill_r    <= fill_nxt;
      x1_r      <= x1_nxt;
      xr_r      <= xr_nxt;
      bw_r      <= bw_nxt;
      y1_r      <= y1_nxt;
      yr_r      <= yr_nxt;
      bh_r      <= bh_nxt;
      if (state_r == bada_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state_r == bada_pkg::S_PREP && prep_ready) begin
      qs_r <= xdiv_quo;
      rs_r <= xdiv_rem;
      qh_r <= ydiv_quo;
      rh_r <= ydiv_rem;
    end
    if (accept) begin
      px_r <= in_src_pixel;
    end
    if (state_r == bada_pkg::S_UPD && emit) begin
      sum_lat_r  <= new_sums;
      n_r        <= NW'(bw_r * bh_r);
      res_col_r  <= dx_r;
      res_row_r  <= dy_r;
      res_last_r <= (dx_inc == ow_r) && (dy_inc == {1'b0, oh_r});
    end
    if (state_r == bada_pkg::S_DIV && rdiv_done) begin
      res_rgb_r <= {rdiv_quo[7:0], gdiv_quo[7:0], bdiv_quo[7:0]};
    end
    if (state_r == bada_pkg::S_OUT && out_free) begin
      out_pixel_r <= {bada_pkg::ALPHA, res_rgb_r};
      out_col_r   <= res_col_r;
      out_row_r   <= res_row_r;
      out_last_r  <= res_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_last = out_last_r;

  // the three channel dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (rdiv_done == gdiv_done) && (rdiv_done == bdiv_done)
    && (rdiv_busy == gdiv_busy) && (rdiv_busy == bdiv_busy))
    else $error("channel dividers out of step");

  // the current block index stays below the configured width while updating
  a_dx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bada_pkg::S_UPD |-> ({1'b0, dx_r} < ow_r))
    else $error("block column out of range");

  // a divide never starts with a zero pixel count
  a_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bada_pkg::S_DIVGO |-> (n_r != '0))
    else $error("zero pixel count at divide");

  // an accepted item is updated in the next cycle unless a register write comes with it
  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_wr_en |=> (state_r == bada_pkg::S_UPD))
    else $error("accepted item not updated");

  // the fill count never passes the configured width
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ow_r)
    else $error("fill count beyond width");

  // the step dividers finish only during setup
  a_prep_done: assert property (@(posedge clk) disable iff (!rst_n)
    (xdiv_done || ydiv_done) |-> (state_r == bada_pkg::S_PREP))
    else $error("step divide finished outside setup");

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the box area average downscaler: random raster stimulus and a predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int SRC_W      = 256;
  localparam int SRC_H      = 192;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 60;    // covers a channel divide in flight plus margin
  localparam int RAND_ITEMS = 1050;

  // one expected output pixel
  typedef struct {
    logic [bada_pkg::PIX_W-1:0] pix;
    logic [bada_pkg::COL_W-1:0] col;
    logic [bada_pkg::ROW_W-1:0] row;
    logic                       last;
  } down_pix_t;

  // Keeps a private copy of the downscaler state and the queue of
  // averaged pixels still owed by the block.
  class downscale_board;
    int unsigned out_w, out_h;
    int unsigned scol, srow, ocol, orow;
    int unsigned red_acc[SRC_W], grn_acc[SRC_W], blu_acc[SRC_W];
    down_pix_t   owed[$];
    int          errors;

    function new();
      out_w  = bada_pkg::MAX_OUT_W;
      out_h  = bada_pkg::MAX_OUT_H;
      errors = 0;
      restart();
    endfunction

    function void restart();
      scol = 0; srow = 0; ocol = 0; orow = 0;
      foreach (red_acc[i]) begin
        red_acc[i] = 0; grn_acc[i] = 0; blu_acc[i] = 0;
      end
    endfunction

    // register write: saturate, then restart the frame
    function void write_reg(logic idx, int unsigned val);
      int unsigned v;
      v = (val < 1) ? 1 : val;
      if (idx == bada_pkg::CFG_OUT_WIDTH)
        out_w = (v > bada_pkg::MAX_OUT_W) ? bada_pkg::MAX_OUT_W : v;
      else
        out_h = (v > bada_pkg::MAX_OUT_H) ? bada_pkg::MAX_OUT_H : v;
      restart();
    endfunction

    function void note_pixel(logic [bada_pkg::PIX_W-1:0] px, logic fs);
      int unsigned dx, dy, x0, x1, y0, y1, n;
      down_pix_t e;
      if (fs) restart();
      dx = ocol & (SRC_W - 1);
      dy = orow;
      red_acc[dx] = (red_acc[dx] + px[23:16]) & 24'hFFFFFF;
      grn_acc[dx] = (grn_acc[dx] + px[15:8]) & 24'hFFFFFF;
      blu_acc[dx] = (blu_acc[dx] + px[7:0]) & 24'hFFFFFF;
      x0 = dx * SRC_W / out_w;
      x1 = (dx + 1) * SRC_W / out_w;
      if (x1 < x0 + 1) x1 = x0 + 1;
      y0 = dy * SRC_H / out_h;
      y1 = (dy + 1) * SRC_H / out_h;
      if (y1 < y0 + 1) y1 = y0 + 1;
      if (scol + 1 >= x1) begin
        if (srow + 1 >= y1) begin
          // bottom-right pixel of the block: average and clear the column
          n = (x1 - x0) * (y1 - y0);
          e.pix  = {bada_pkg::ALPHA, 8'(red_acc[dx] / n), 8'(grn_acc[dx] / n),
                    8'(blu_acc[dx] / n)};
          e.col  = dx[7:0];
          e.row  = dy[7:0];
          e.last = (dx + 1 == out_w) && (dy + 1 == out_h);
          owed.push_back(e);
          red_acc[dx] = 0; grn_acc[dx] = 0; blu_acc[dx] = 0;
        end
        ocol = dx + 1;
      end
      scol++;
      if (scol >= SRC_W) begin
        scol = 0;
        ocol = 0;
        if (srow + 1 >= y1) orow = dy + 1;
        srow++;
        if (srow >= SRC_H) begin
          srow = 0;
          orow = 0;
        end
      end
      if (ocol >= out_w) ocol = 0;
      if (orow >= out_h) orow = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_pixel(logic [bada_pkg::PIX_W-1:0] pix, logic [bada_pkg::COL_W-1:0] col,
                     logic [bada_pkg::ROW_W-1:0] row, logic last);
      down_pix_t e;
      if (owed.size() == 0) begin
        report("unexpected output pixel", pix, 0);
      end else begin
        e = owed.pop_front();
        if (pix !== e.pix)   report("out_pixel", pix, e.pix);
        if (col !== e.col)   report("out_col", col, e.col);
        if (row !== e.row)   report("out_row", row, e.row);
        if (last !== e.last) report("out_frame_last", last, e.last);
      end
    endtask
  endclass

  logic                       clk, rst_n;
  logic                       in_valid, in_stall, in_frame_start;
  logic [bada_pkg::PIX_W-1:0] in_src_pixel;
  logic                       out_valid, out_stall, out_frame_last;
  logic [bada_pkg::PIX_W-1:0] out_pixel;
  logic [bada_pkg::COL_W-1:0] out_col;
  logic [bada_pkg::ROW_W-1:0] out_row;
  logic                       cfg_wr_en, cfg_index;
  logic [bada_pkg::CFG_W-1:0] cfg_data;

  downscale_board board = new();
  int             tx_gap_max, rx_gap_max;  // per-phase idling ceilings
  int             hold_off;                // long receiver stall request
  int             rx_wait;
  int             cycle_count;
  int             sent;

  box_area_average_downscaler_unit #(.SRC_WIDTH(SRC_W), .SRC_HEIGHT(SRC_H)) dut (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: check at each accepting edge, then draw a stall for the next item.
  // A hold_off request stalls for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_pixel(out_pixel, out_col, out_row, out_frame_last);
      rx_wait = $urandom_range(0, rx_gap_max);
    end
    if (hold_off > 0) begin
      hold_off  = hold_off - 1;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait   = rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // offer one pixel after a random gap, wait for it to be taken
  task send_pixel(logic [bada_pkg::PIX_W-1:0] px, logic fs);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_src_pixel   <= px;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    board.note_pixel(px, fs);
    sent++;
  endtask

  // let owed pixels drain, then a few more cycles for a divide in flight
  task drain();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [bada_pkg::CFG_W-1:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.write_reg(idx, val);
  endtask

  initial begin
    int n, pick;
    rst_n = 1'b0;
    in_valid = 1'b0; in_src_pixel = '0; in_frame_start = 1'b0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = bada_pkg::CFG_OUT_WIDTH; cfg_data = '0;
    tx_gap_max = 3; rx_gap_max = 3;
    hold_off = 0; rx_wait = 0; cycle_count = 0; sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset size 256x192, every pixel is its own block.
    send_pixel(32'h00000000, 1'b1);
    send_pixel(32'hFFFFFFFF, 1'b0);
    send_pixel(32'h00FF0000, 1'b0);
    send_pixel(32'h0000FF00, 1'b0);
    send_pixel(32'h000000FF, 1'b0);
    send_pixel(32'hFF000000, 1'b0);
    send_pixel(32'h12345678, 1'b1);   // frame start mid-row resyncs
    send_pixel(32'hA5C3E1F0, 1'b0);
    // zero writes saturate up to 1x1
    write_reg(bada_pkg::CFG_OUT_WIDTH, 9'd0);
    write_reg(bada_pkg::CFG_OUT_HEIGHT, 9'd0);
    for (int i = 0; i < 5; i++) send_pixel(32'hFFFFFFFF, 1'b0);
    // oversized writes saturate down to 256x192
    write_reg(bada_pkg::CFG_OUT_WIDTH, 9'h1FF);
    write_reg(bada_pkg::CFG_OUT_HEIGHT, 9'd255);
    for (int i = 0; i < 4; i++) send_pixel(32'h80808080, 1'b0);

    // Odd width over one full row and part of the next: uneven block edges
    // and the row wrap. Kept free of idling for speed.
    write_reg(bada_pkg::CFG_OUT_WIDTH, 9'd3);
    write_reg(bada_pkg::CFG_OUT_HEIGHT, 9'd192);
    tx_gap_max = 0; rx_gap_max = 0;
    for (int i = 0; i < 300; i++) send_pixel($urandom, 1'b0);

    // Backpressure: full-size output, receiver holds off while items keep coming.
    write_reg(bada_pkg::CFG_OUT_WIDTH, 9'd256);
    write_reg(bada_pkg::CFG_OUT_HEIGHT, 9'd192);
    tx_gap_max = 0;
    hold_off   = 400;
    for (int i = 0; i < 60; i++) send_pixel($urandom, 1'b0);

    // Random phases.
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: write_reg(bada_pkg::CFG_OUT_WIDTH, 9'd256);
        1: write_reg(bada_pkg::CFG_OUT_WIDTH, 9'd1);
        2: write_reg(bada_pkg::CFG_OUT_WIDTH, 9'($urandom_range(0, 511)));
        default: write_reg(bada_pkg::CFG_OUT_WIDTH, 9'($urandom_range(128, 256)));
      endcase
      pick = $urandom_range(0, 5);
      case (pick)
        0: write_reg(bada_pkg::CFG_OUT_HEIGHT, 9'd1);
        1: write_reg(bada_pkg::CFG_OUT_HEIGHT, 9'($urandom_range(0, 255)));
        default: write_reg(bada_pkg::CFG_OUT_HEIGHT, 9'd192);  // one band per row
      endcase
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      n = $urandom_range(20, 140);
      for (int i = 0; i < n; i++)
        send_pixel($urandom, ($urandom_range(0, 99) < 3));
    end

    drain();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
